// File: sv/bblt_pkg.sv
// Package for the bit-aligned rectangle copier: command, status and register codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package bblt_pkg;

	// Command codes carried on the slave tuser
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_COPY  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Status codes carried on the master tuser
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_START_OUT = 2'd1;
	localparam logic [1:0] STAT_SRC_OUT   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_PITCH      = 2'd0;
	localparam logic [1:0] REG_PIXEL_BITS = 2'd1;
	localparam logic [1:0] REG_SCR_W      = 2'd2;
	localparam logic [1:0] REG_SCR_H      = 2'd3;

	// Register reset values
	localparam logic [14:0] PITCH_RST      = 15'd256;
	localparam logic [5:0]  PIXEL_BITS_RST = 6'd8;
	localparam logic [12:0] SCR_W_RST      = 13'd256;
	localparam logic [12:0] SCR_H_RST      = 13'd256;

	// Width of intermediate address arithmetic
	localparam int CALC_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_CHK,
		ST_CHK2,
		ST_ROW,
		ST_ROW2,
		ST_CHUNK,
		ST_RD0,
		ST_RD1,
		ST_RDD,
		ST_WR,
		ST_DONE
	} state_t;

	// Per-cycle command from the controller to the datapath
	typedef struct packed {
		logic mem_rd;   // read frame memory at the given word
		logic mem_wr;   // write frame memory at the given word
		logic merge;    // write data is the masked merge, not the plain word
		logic cap_w0;   // hold first source word
		logic cap_sh;   // hold funnel-shifted source
	} dp_ctrl_t;

endpackage

// File: sv/bit_aligned_rect_copy.sv
// Top level of the bit-aligned rectangle copier over an internal frame memory.
// Instantiates bblt_ctrl and bblt_dp; depends on bblt_pkg.
//
// Usage:
//  - cfg channel writes line pitch (bytes), pixel bits, screen width and height;
//    it is always ready and should be written only while no command is in flight.
//  - Slave stream: tuser holds the command (read word, write word, copy area),
//    tdata the address, write word and copy rectangle. One command at a time.
//  - Master stream: one transfer per command; tdata the word read (zero for other
//    commands), tuser the copy status.
//  - Read and write: the access state, then ST_DONE, which loads the result register;
//    the next command is taken once the controller is back in idle.
//  - A copy runs ST_CHK and ST_CHK2, then ST_ROW and ST_ROW2 per row, and ST_CHUNK,
//    ST_RD0, ST_RD1, ST_RDD and ST_WR per destination word chunk: three reads and one
//    write of the single memory port. ST_DONE loads the result; a rejected copy ends
//    after its checks. The result register holds while the receiver stalls; the next
//    command is taken once the current result is in that register.
//  - Reset clears the control state and restores the register defaults; frame
//    memory contents are undefined until written. WORD_BITS and FRAME_WORDS
//    are powers of two.
module bit_aligned_rect_copy import bblt_pkg::*; #(
	parameter int WORD_BITS   = 32,
	parameter int FRAME_WORDS = 16384
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// word_address[13:0], write_data[45:14], src_x[57:46], src_y[69:58],
	// dst_x[81:70], dst_y[93:82], area_width[106:94], area_height[119:107]
	input  logic [119:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_data[31:0]
	output logic [31:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	localparam int LW = $clog2(WORD_BITS);
	localparam int AW = $clog2(FRAME_WORDS);

	dp_ctrl_t             ctl;
	logic [AW-1:0]        addr;
	logic [LW-1:0]        off_s, off_d;
	logic [LW:0]          cnt;
	logic [WORD_BITS-1:0] wr_word, rdata;

	bblt_ctrl #(
		.WORD_BITS   (WORD_BITS),
		.FRAME_WORDS (FRAME_WORDS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.ctl           (ctl),
		.addr          (addr),
		.off_s         (off_s),
		.off_d         (off_d),
		.cnt           (cnt),
		.wr_word       (wr_word),
		.rdata         (rdata)
	);

	bblt_dp #(
		.WORD_BITS   (WORD_BITS),
		.FRAME_WORDS (FRAME_WORDS)
	) u_dp (
		.clk     (clk),
		.ctl     (ctl),
		.addr    (addr),
		.off_s   (off_s),
		.off_d   (off_d),
		.cnt     (cnt),
		.wr_word (wr_word),
		.rdata   (rdata)
	);

endmodule

// File: sv/bblt_dp.sv
// Datapath of the rectangle copier: frame memory, funnel shifter and edge-mask merge.
// Depends on bblt_pkg.
module bblt_dp import bblt_pkg::*; #(
	parameter int WORD_BITS   = 32,
	parameter int FRAME_WORDS = 16384,
	localparam int LW = $clog2(WORD_BITS),
	localparam int AW = $clog2(FRAME_WORDS)
) (
	input  logic                 clk,
	input  dp_ctrl_t             ctl,
	input  logic [AW-1:0]        addr,
	input  logic [LW-1:0]        off_s,
	input  logic [LW-1:0]        off_d,
	input  logic [LW:0]          cnt,
	input  logic [WORD_BITS-1:0] wr_word,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0]   mem [FRAME_WORDS];
	logic [WORD_BITS-1:0]   rdata_q;
	logic [WORD_BITS-1:0]   w0_q;
	logic [WORD_BITS-1:0]   src_q;
	logic [2*WORD_BITS-1:0] funnel;
	logic [WORD_BITS-1:0]   ones;
	logic [WORD_BITS-1:0]   mask;
	logic [WORD_BITS-1:0]   placed;
	logic [WORD_BITS-1:0]   merged;
	logic [WORD_BITS-1:0]   wdata;
	logic [LW:0]            end_off;

	// Source bits starting at the source offset, MSB-aligned
	assign funnel = {w0_q, rdata_q} << off_s;

	// Edge masks keep destination bits outside the chunk
	assign ones    = '1;
	assign end_off = {1'b0, off_d} + cnt;
	assign mask    = (ones >> off_d) & ~(ones >> end_off);
	assign placed  = src_q >> off_d;
	assign merged  = (rdata_q & ~mask) | (placed & mask);
	assign wdata   = ctl.merge ? merged : wr_word;

	// Single-port frame memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	// Source word holding registers
	always_ff @(posedge clk) begin
		if (ctl.cap_w0) begin
			w0_q <= rdata_q;
		end
		if (ctl.cap_sh) begin
			src_q <= funnel[2*WORD_BITS-1:WORD_BITS];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/bblt_ctrl.sv
// Controller of the rectangle copier: handshakes, configuration registers, clipping,
// row and chunk sequencing. Drives bblt_dp through dp_ctrl_t. Depends on bblt_pkg.
module bblt_ctrl import bblt_pkg::*; #(
	parameter int WORD_BITS   = 32,
	parameter int FRAME_WORDS = 16384,
	localparam int LW = $clog2(WORD_BITS),
	localparam int AW = $clog2(FRAME_WORDS),
	localparam int BA = AW + LW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [14:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [119:0]         s_axis_tdata,
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,
	output logic [1:0]           m_axis_tuser,
	output dp_ctrl_t             ctl,
	output logic [AW-1:0]        addr,
	output logic [LW-1:0]        off_s,
	output logic [LW-1:0]        off_d,
	output logic [LW:0]          cnt,
	output logic [WORD_BITS-1:0] wr_word,
	input  logic [WORD_BITS-1:0] rdata
);

	state_t state_q, state_nx;

	// Configuration
	logic [14:0] pitch_q;
	logic [5:0]  pix_q;
	logic [12:0] scr_w_q, scr_h_q;

	// Captured item
	logic [1:0]  cmd_q;
	logic [13:0] waddr_q;
	logic [31:0] wdata_q;
	logic [11:0] sx_q, sy_q, dx_q, dy_q;
	logic [12:0] aw_q, ah_q;

	// Copy geometry
	logic [12:0] wc_q, hc_q, row_q;
	logic        rev_q;
	logic [1:0]  stat_q;
	logic [18:0] n_q, pos_q;
	logic [17:0] dxpb_q, sxpb_q;
	logic [30:0] prod_d_q, prod_s_q;
	logic [BA-1:0] d_q, s_q, da_q, sa_q;
	logic [LW:0]   c_q;

	// Output register
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic [1:0]  m_user_q;

	logic        s_acc, out_free;
	logic [13:0] x2, y2;
	logic [12:0] x2c, y2c, wc, hc;
	logic        start_out, src_out, rev;
	logic [12:0] line_d, line_s;
	logic [17:0] pitch_bits;
	logic [30:0] prod_d, prod_s;
	logic [CALC_W-1:0] dsum, ssum;
	logic [CALC_W-1:0] da_f32, e32, da_r32, sa32;
	logic [LW:0]   avail_f, avail_r, c_f, c_r, c_nx;
	logic [18:0]   rem, npos_r;
	logic          last_chunk;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Start check and destination clip
	assign start_out = ({1'b0, dx_q} > scr_w_q) || ({1'b0, sx_q} > scr_w_q) ||
		({1'b0, dy_q} > scr_h_q) || ({1'b0, sy_q} > scr_h_q);
	assign x2  = {2'b0, dx_q} + {1'b0, aw_q};
	assign y2  = {2'b0, dy_q} + {1'b0, ah_q};
	assign x2c = (x2 > {1'b0, scr_w_q}) ? scr_w_q : x2[12:0];
	assign y2c = (y2 > {1'b0, scr_h_q}) ? scr_h_q : y2[12:0];
	assign wc  = x2c - {1'b0, dx_q};
	assign hc  = y2c - {1'b0, dy_q};
	assign rev = (dy_q > sy_q) || ((dy_q == sy_q) && (dx_q > sx_q));

	// Source check on the clipped size
	assign src_out = (({2'b0, sx_q} + {1'b0, wc_q}) > {1'b0, scr_w_q}) ||
		(({2'b0, sy_q} + {1'b0, hc_q}) > {1'b0, scr_h_q});

	// Row start bit addresses
	assign line_d     = rev_q ? ({1'b0, dy_q} + hc_q - 13'd1 - row_q) : ({1'b0, dy_q} + row_q);
	assign line_s     = rev_q ? ({1'b0, sy_q} + hc_q - 13'd1 - row_q) : ({1'b0, sy_q} + row_q);
	assign pitch_bits = {pitch_q, 3'b000};
	assign prod_d     = {18'b0, line_d} * {13'b0, pitch_bits};
	assign prod_s     = {18'b0, line_s} * {13'b0, pitch_bits};
	assign dsum       = {1'b0, prod_d_q} + CALC_W'(dxpb_q);
	assign ssum       = {1'b0, prod_s_q} + CALC_W'(sxpb_q);

	// Forward chunk: up to the end of the destination word
	assign da_f32  = CALC_W'(d_q) + CALC_W'(pos_q);
	assign avail_f = (LW+1)'(WORD_BITS) - {1'b0, da_f32[LW-1:0]};
	assign rem     = n_q - pos_q;
	assign c_f     = (rem < 19'(avail_f)) ? rem[LW:0] : avail_f;

	// Reverse chunk: back to the start of the destination word
	assign e32     = CALC_W'(d_q) + CALC_W'(pos_q) - CALC_W'(1);
	assign avail_r = {1'b0, e32[LW-1:0]} + (LW+1)'(1);
	assign c_r     = (pos_q < 19'(avail_r)) ? pos_q[LW:0] : avail_r;
	assign npos_r  = pos_q - 19'(c_r);
	assign da_r32  = CALC_W'(d_q) + CALC_W'(npos_r);
	assign sa32    = CALC_W'(s_q) + CALC_W'(rev_q ? npos_r : pos_q);
	assign c_nx    = rev_q ? c_r : c_f;

	assign last_chunk = rev_q ? (pos_q == 19'd0) : (pos_q == n_q);

	assign off_s   = sa_q[LW-1:0];
	assign off_d   = da_q[LW-1:0];
	assign cnt     = c_q;
	assign wr_word = WORD_BITS'(wdata_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		addr     = AW'(waddr_q);
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					case (s_axis_tuser)
						CMD_READ:  state_nx = ST_READ;
						CMD_WRITE: state_nx = ST_WRITE;
						CMD_COPY:  state_nx = ST_CHK;
						default:   state_nx = ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				ctl.mem_rd = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_WRITE: begin
				ctl.mem_wr = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_CHK: state_nx = start_out ? ST_DONE : ST_CHK2;
			ST_CHK2: state_nx = src_out ? ST_DONE : ST_ROW;
			ST_ROW: state_nx = ((n_q == 19'd0) || (hc_q == 13'd0)) ? ST_DONE : ST_ROW2;
			ST_ROW2: state_nx = ST_CHUNK;
			ST_CHUNK: state_nx = ST_RD0;
			ST_RD0: begin
				ctl.mem_rd = 1'b1;
				addr       = sa_q[BA-1:LW];
				state_nx   = ST_RD1;
			end
			ST_RD1: begin
				ctl.mem_rd = 1'b1;
				ctl.cap_w0 = 1'b1;
				addr       = sa_q[BA-1:LW] + AW'(1);
				state_nx   = ST_RDD;
			end
			ST_RDD: begin
				ctl.mem_rd = 1'b1;
				ctl.cap_sh = 1'b1;
				addr       = da_q[BA-1:LW];
				state_nx   = ST_WR;
			end
			ST_WR: begin
				ctl.mem_wr = 1'b1;
				ctl.merge  = 1'b1;
				addr       = da_q[BA-1:LW];
				if (!last_chunk) begin
					state_nx = ST_CHUNK;
				end else if (row_q == hc_q - 13'd1) begin
					state_nx = ST_DONE;
				end else begin
					state_nx = ST_ROW;
				end
			end
			ST_DONE: state_nx = out_free ? ST_IDLE : ST_DONE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RST;
			pix_q   <= PIXEL_BITS_RST;
			scr_w_q <= SCR_W_RST;
			scr_h_q <= SCR_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PITCH:      pitch_q <= cfg_data;
				REG_PIXEL_BITS: pix_q   <= cfg_data[5:0];
				REG_SCR_W:      scr_w_q <= cfg_data[12:0];
				REG_SCR_H:      scr_h_q <= cfg_data[12:0];
				default:        pitch_q <= pitch_q;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= (cmd_q == CMD_READ) ? rdata[31:0] : 32'd0;
			m_user_q <= (cmd_q == CMD_COPY) ? stat_q : STAT_DONE;
		end
	end

	// Item capture and copy sequencing
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					cmd_q   <= s_axis_tuser;
					waddr_q <= s_axis_tdata[13:0];
					wdata_q <= s_axis_tdata[45:14];
					sx_q    <= s_axis_tdata[57:46];
					sy_q    <= s_axis_tdata[69:58];
					dx_q    <= s_axis_tdata[81:70];
					dy_q    <= s_axis_tdata[93:82];
					aw_q    <= s_axis_tdata[106:94];
					ah_q    <= s_axis_tdata[119:107];
					stat_q  <= STAT_DONE;
				end
			end
			ST_CHK: begin
				stat_q <= start_out ? STAT_START_OUT : STAT_DONE;
				wc_q   <= wc;
				hc_q   <= hc;
				rev_q  <= rev;
			end
			ST_CHK2: begin
				stat_q <= src_out ? STAT_SRC_OUT : STAT_DONE;
				n_q    <= {6'b0, wc_q} * {13'b0, pix_q};
				dxpb_q <= {6'b0, dx_q} * {12'b0, pix_q};
				sxpb_q <= {6'b0, sx_q} * {12'b0, pix_q};
				row_q  <= 13'd0;
			end
			ST_ROW: begin
				prod_d_q <= prod_d;
				prod_s_q <= prod_s;
			end
			ST_ROW2: begin
				d_q   <= dsum[BA-1:0];
				s_q   <= ssum[BA-1:0];
				pos_q <= rev_q ? n_q : 19'd0;
			end
			ST_CHUNK: begin
				da_q  <= rev_q ? da_r32[BA-1:0] : da_f32[BA-1:0];
				sa_q  <= sa32[BA-1:0];
				c_q   <= c_nx;
				pos_q <= rev_q ? npos_r : (pos_q + 19'(c_f));
			end
			ST_WR: begin
				if (last_chunk) begin
					row_q <= row_q + 13'd1;
				end
			end
			default: begin
				row_q <= row_q;
			end
		endcase
	end

	// A chunk written never runs past the end of its destination word
	a_chunk_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (c_q != '0) && (({1'b0, off_d} + c_q) <= (LW+1)'(WORD_BITS)))
		else $error("chunk crosses destination word");

	// Memory is never read and written in the same cycle
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.mem_rd && ctl.mem_wr))
		else $error("read and write together");

	// Row position stays inside the row
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHUNK || state_q == ST_WR) |-> (pos_q <= n_q))
		else $error("row position beyond row length");

	// An accepted item always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q != ST_IDLE))
		else $error("accepted item not started");

endmodule
